FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define KRG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, reset masked.
`define KRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hdl/krg_pkg.sv
`default_nettype none
package krg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ACC_W = 64;
	localparam int DIV_STEPS = ACC_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] pred_row;
		logic [2:0] input_index;
		logic signed [31:0] kernel_derivative;
		logic signed [31:0] dist_derivative;
		logic signed [31:0] label_0;
		logic signed [31:0] label_1;
		logic signed [31:0] kbar_0;
		logic signed [31:0] kbar_1;
		logic signed [31:0] ybar_0;
		logic signed [31:0] ybar_1;
		logic last_train;
	} item_t;

	typedef struct packed {
		logic [7:0] row_out;
		logic [2:0] dim_out;
		logic signed [31:0] grad_0;
		logic signed [31:0] grad_1;
		logic zero_divisor;
		logic saturated;
	} result_t;

	// one finished run, handed from accumulator to divider
	typedef struct packed {
		logic [7:0] row;
		logic [2:0] dim;
		logic signed [ACC_W-1:0] sum_weight;
		logic signed [ACC_W-1:0] sum_label_0;
		logic signed [ACC_W-1:0] sum_label_1;
		logic signed [31:0] kbar_0;
		logic signed [31:0] kbar_1;
		logic signed [31:0] ybar_0;
		logic signed [31:0] ybar_1;
	} job_t;

	typedef struct packed {
		logic full;
		logic valid;
	} queue_status_t;

	function automatic logic ovf32(input logic signed [ACC_W-1:0] x);
		return !((&x[ACC_W-1:31]) || !(|x[ACC_W-1:31]));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		if (!ovf32(x))
			return x[31:0];
		else if (x[ACC_W-1])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/kernel_ratio_gradient.sv
`default_nettype none
// Accumulates kernel-weighted sums over a run of training beats and emits one
// gradient pair per run by the quotient rule. The accumulator takes a beat only when
// idle and then steps through product, weight and label products, and add before
// the next, an order fixed by its two chained multiplies. A run's last beat hands its
// sums to a two-entry queue; the divider behind it does load, multiply, subtract,
// bit-serial long division and finish for each of the two outputs at Q16.16, so runs
// shorter than about 57 beats stall the input once the queue fills. Values are
// Q16.16; results clamp and flag.
`include "assert_macros.svh"
module kernel_ratio_gradient (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire krg_pkg::item_t item,
	output logic result_valid,
	input wire logic result_stall,
	output krg_pkg::result_t result
);
	import krg_pkg::*;

	logic push, pop;
	job_t push_data, pop_data;
	queue_status_t q_status;

	krg_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.q_status(q_status),
		.push(push),
		.push_data(push_data)
	);

	krg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.status(q_status)
	);

	krg_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_status(q_status),
		.pop_data(pop_data),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	`KRG_ASSERT_NEXT(a_front_busy, clk, arst_n, item_valid && !item_stall, item_stall)
	`KRG_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !q_status.full || pop)
	`KRG_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, q_status.valid)

endmodule
`default_nettype wire

FILE: hdl/krg_queue.sv
`default_nettype none
module krg_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire krg_pkg::job_t push_data,
	input wire logic pop,
	output krg_pkg::job_t pop_data,
	output krg_pkg::queue_status_t status
);
	import krg_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0] count_q;

	assign status.full = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign status.valid = (count_q != '0);
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/krg_front.sv
`default_nettype none
module krg_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire krg_pkg::item_t item,
	input wire krg_pkg::queue_status_t q_status,
	output logic push,
	output krg_pkg::job_t push_data
);
	import krg_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_WEIGHT = 2'd1;
	localparam logic [1:0] F_ACC = 2'd2;

	logic [1:0] state_q;
	item_t item_q;
	logic signed [63:0] prod_q, term0_q, term1_q;
	logic signed [31:0] s_q;
	logic signed [ACC_W-1:0] sum_w_q, sum_0_q, sum_1_q;
	logic signed [ACC_W-1:0] new_w, new_0, new_1;
	logic signed [31:0] s_next;
	logic take;

	// a whole queue slot must be free before a beat is taken
	assign item_stall = !(state_q == F_IDLE && !q_status.full);
	assign take = item_valid && !item_stall;

	assign s_next = sat32(prod_q >>> FRAC_BITS);
	assign new_w = sum_w_q + ACC_W'(s_q);
	assign new_0 = sum_0_q + (term0_q >>> FRAC_BITS);
	assign new_1 = sum_1_q + (term1_q >>> FRAC_BITS);

	assign push = (state_q == F_ACC) && item_q.last_train;
	always_comb begin
		push_data.row = item_q.pred_row;
		push_data.dim = item_q.input_index;
		push_data.sum_weight = new_w;
		push_data.sum_label_0 = new_0;
		push_data.sum_label_1 = new_1;
		push_data.kbar_0 = item_q.kbar_0;
		push_data.kbar_1 = item_q.kbar_1;
		push_data.ybar_0 = item_q.ybar_0;
		push_data.ybar_1 = item_q.ybar_1;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item;
			prod_q <= item.kernel_derivative * item.dist_derivative;
		end
		if (state_q == F_WEIGHT) begin
			s_q <= s_next;
			term0_q <= s_next * item_q.label_0;
			term1_q <= s_next * item_q.label_1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			sum_w_q <= '0;
			sum_0_q <= '0;
			sum_1_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (take)
						state_q <= F_WEIGHT;
				end
				F_WEIGHT: state_q <= F_ACC;
				F_ACC: begin
					state_q <= F_IDLE;
					if (item_q.last_train) begin
						sum_w_q <= '0;
						sum_0_q <= '0;
						sum_1_q <= '0;
					end else begin
						sum_w_q <= new_w;
						sum_0_q <= new_0;
						sum_1_q <= new_1;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/krg_back.sv
`default_nettype none
module krg_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire krg_pkg::queue_status_t q_status,
	input wire krg_pkg::job_t pop_data,
	output logic pop,
	output logic result_valid,
	input wire logic result_stall,
	output krg_pkg::result_t result
);
	import krg_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_LOAD = 3'd1;
	localparam logic [2:0] B_MUL = 3'd2;
	localparam logic [2:0] B_SUB = 3'd3;
	localparam logic [2:0] B_DIV = 3'd4;
	localparam logic [2:0] B_FIN = 3'd5;
	localparam logic [2:0] B_OUT = 3'd6;

	logic [2:0] state_q;
	job_t job_q;
	logic sel_q;
	logic signed [31:0] dy_q, dk_q, kb_q, yb_q;
	logic hit_q;
	logic signed [63:0] a_q, b_q;
	logic [63:0] den_q, mag_q, rem_q;
	logic neg_q;
	logic [32:0] quo_q;
	logic sticky_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [31:0] g0_q, g1_q;
	logic zero_q, sat_q;
	logic valid_q;
	result_t result_q;

	logic [64:0] trial;
	logic fits;
	logic [32:0] limit;
	logic over;
	logic [32:0] mclamp;
	logic [31:0] g_fin;
	logic signed [ACC_W-1:0] sum_sel;
	logic take_out;

	assign pop = (state_q == B_IDLE) && q_status.valid;
	assign result_valid = valid_q;
	assign result = result_q;
	assign take_out = (state_q == B_OUT) && (!valid_q || !result_stall);

	assign sum_sel = sel_q ? job_q.sum_label_1 : job_q.sum_label_0;

	// restoring divider, one quotient bit per cycle
	assign trial = {rem_q, mag_q[63]};
	assign fits = (trial >= {1'b0, den_q});

	assign limit = neg_q ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
	assign over = sticky_q || (quo_q > limit);
	assign mclamp = over ? limit : quo_q;
	assign g_fin = neg_q ? 32'(-mclamp) : mclamp[31:0];

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (q_status.valid)
					job_q <= pop_data;
			end
			B_LOAD: begin
				dy_q <= sat32(sum_sel);
				dk_q <= sat32(job_q.sum_weight);
				hit_q <= ovf32(sum_sel) || ovf32(job_q.sum_weight);
				kb_q <= sel_q ? job_q.kbar_1 : job_q.kbar_0;
				yb_q <= sel_q ? job_q.ybar_1 : job_q.ybar_0;
			end
			B_MUL: begin
				a_q <= dy_q * kb_q;
				b_q <= yb_q * dk_q;
				den_q <= 64'(kb_q * kb_q);
			end
			B_SUB: begin
				neg_q <= (a_q < b_q);
				mag_q <= (a_q < b_q) ? 64'(b_q - a_q) : 64'(a_q - b_q);
				rem_q <= '0;
				quo_q <= '0;
				sticky_q <= 1'b0;
				cnt_q <= '0;
			end
			B_DIV: begin
				mag_q <= mag_q << 1;
				rem_q <= fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
				quo_q <= {quo_q[31:0], fits};
				sticky_q <= sticky_q || quo_q[32];
				cnt_q <= cnt_q + 1'b1;
			end
			B_FIN: begin
				if (sel_q)
					g1_q <= (kb_q == '0) ? '0 : g_fin;
				else
					g0_q <= (kb_q == '0) ? '0 : g_fin;
			end
			B_OUT: begin
				if (take_out) begin
					result_q.row_out <= job_q.row;
					result_q.dim_out <= job_q.dim;
					result_q.grad_0 <= g0_q;
					result_q.grad_1 <= g1_q;
					result_q.zero_divisor <= zero_q;
					result_q.saturated <= sat_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			sel_q <= 1'b0;
			zero_q <= 1'b0;
			sat_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (take_out)
				valid_q <= 1'b1;
			else if (!result_stall)
				valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (q_status.valid) begin
						sel_q <= 1'b0;
						zero_q <= 1'b0;
						sat_q <= 1'b0;
						state_q <= B_LOAD;
					end
				end
				B_LOAD: state_q <= B_MUL;
				B_MUL: state_q <= B_SUB;
				B_SUB: state_q <= B_DIV;
				B_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_q <= B_FIN;
				end
				B_FIN: begin
					if (kb_q == '0)
						zero_q <= 1'b1;
					else if (hit_q || over)
						sat_q <= 1'b1;
					if (!sel_q) begin
						sel_q <= 1'b1;
						state_q <= B_LOAD;
					end else begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (take_out)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
